### sv/esd_pkg.sv
// Shared phase codes, character constants and step result type for the escape decoder.
`default_nettype none

package esd_pkg;

  // Phase codes of the decoder state.
  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_START = 3'd0;
  localparam logic [PhaseW-1:0] PH_HEX1  = 3'd1;
  localparam logic [PhaseW-1:0] PH_HEX2  = 3'd2;
  localparam logic [PhaseW-1:0] PH_OCT2  = 3'd3;
  localparam logic [PhaseW-1:0] PH_OCT3  = 3'd4;

  // Characters that the decoder recognizes or produces.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_BSLSH = 8'h5C;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_LO_T  = 8'h74;
  localparam logic [7:0] CH_LO_V  = 8'h76;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_7 = 8'h37;
  localparam logic [7:0] CH_DIG_9 = 8'h39;

  // Offset that turns the low nibble of a hex letter into its value.
  localparam logic [3:0] HexLetterOfs = 4'd9;

  // Outcome of one decoder step.
  typedef struct packed {
    logic              emit;
    logic [7:0]        decoded;
    logic              invalid;
    logic              consumed;
    logic [PhaseW-1:0] phase;
    logic [7:0]        accum;
  } step_t;

endpackage

`default_nettype wire

### sv/escape_sequence_decoder_unit.sv
// Top level of the escape decoder: input register, decode step and result register.
// A word taken into the input register passes the decode step and, if it finishes an escape,
// is written to the result register; a word that finishes no escape only updates the phase
// and accumulator.
// Throughput: one word per cycle; the result register is the only point where the stream stalls.
// Reset: rst_ni is asynchronous and active low; it empties both registers and returns the
// phase to the start of an escape with a clear accumulator.
`default_nettype none

module escape_sequence_decoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [7:0] decoded, [8] invalid, [9] consumed, rest 0
);

  logic                      in_vld_q;
  logic [7:0]                in_ch_q;
  logic [esd_pkg::PhaseW-1:0] phase_q;
  logic [7:0]                accum_q;
  logic                      out_vld_q;
  logic [7:0]                out_decoded_q;
  logic                      out_invalid_q;
  logic                      out_consumed_q;
  logic                      advance;
  esd_pkg::step_t            step;

  // A word leaves the input register when the result register is free or being drained.
  assign advance       = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_ch_q <= s_axis_tdata;
    end
  end

  // Decode step on the registered word.
  esd_step u_step (
    .phase_i (phase_q),
    .accum_i (accum_q),
    .ch_i    (in_ch_q),
    .step_o  (step)
  );

  // Escape state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= esd_pkg::PH_START;
      accum_q <= 8'd0;
    end else if (advance) begin
      phase_q <= step.phase;
      accum_q <= step.accum;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= step.emit;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step.emit) begin
      out_decoded_q  <= step.decoded;
      out_invalid_q  <= step.invalid;
      out_consumed_q <= step.consumed;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_consumed_q, out_invalid_q, out_decoded_q};

  // A malformed escape always leaves its last byte to the caller.
  a_invalid_not_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_invalid_q && out_consumed_q))
    else $error("invalid result marked as consumed");

  // A finished escape returns to the start phase with a clear accumulator.
  a_emit_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && step.emit) |=> (phase_q == esd_pkg::PH_START && accum_q == 8'd0))
    else $error("state not restarted after a result");

  // Only one hex digit is held while waiting for the second.
  a_hex_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == esd_pkg::PH_HEX2) |-> (accum_q[7:4] == 4'd0))
    else $error("hex accumulator wider than one digit");

  // A word moving on with a full, stalled result register would overwrite it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |-> !advance)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

### sv/esd_step.sv
// Combinational step of the escape decoder: next phase, accumulator and result.
`default_nettype none

module esd_step (
  input  wire logic [esd_pkg::PhaseW-1:0] phase_i,
  input  wire logic [7:0]                 accum_i,
  input  wire logic [7:0]                 ch_i,
  output esd_pkg::step_t                  step_o
);

  logic       is_dec;
  logic       is_lo_hex;
  logic       is_up_hex;
  logic       is_hex;
  logic       is_oct;
  logic [3:0] hex_val;

  // Character classes and the value of a hex digit.
  always_comb begin
    is_dec    = (ch_i inside {[esd_pkg::CH_DIG_0:esd_pkg::CH_DIG_9]});
    is_lo_hex = (ch_i inside {[esd_pkg::CH_LO_A:esd_pkg::CH_LO_F]});
    is_up_hex = (ch_i inside {[esd_pkg::CH_UP_A:esd_pkg::CH_UP_F]});
    is_hex    = is_dec | is_lo_hex | is_up_hex;
    is_oct    = (ch_i inside {[esd_pkg::CH_DIG_0:esd_pkg::CH_DIG_7]});
    hex_val   = is_dec ? ch_i[3:0] : (ch_i[3:0] + esd_pkg::HexLetterOfs);
  end

  // Phase update; every finished escape returns to the start phase with a clear accumulator.
  always_comb begin
    step_o          = '0;
    step_o.phase    = esd_pkg::PH_START;
    step_o.accum    = 8'd0;
    case (phase_i)
      esd_pkg::PH_HEX1: begin
        if (is_hex) begin
          step_o.phase = esd_pkg::PH_HEX2;
          step_o.accum = {4'd0, hex_val};
        end else begin
          step_o.emit    = 1'b1;
          step_o.decoded = esd_pkg::CH_QUEST;
          step_o.invalid = 1'b1;
        end
      end
      esd_pkg::PH_HEX2: begin
        step_o.emit = 1'b1;
        if (is_hex) begin
          step_o.decoded  = {accum_i[3:0], hex_val};
          step_o.consumed = 1'b1;
        end else begin
          step_o.decoded = esd_pkg::CH_QUEST;
          step_o.invalid = 1'b1;
        end
      end
      esd_pkg::PH_OCT2: begin
        if (is_oct) begin
          step_o.phase = esd_pkg::PH_OCT3;
          step_o.accum = {accum_i[4:0], ch_i[2:0]};
        end else begin
          step_o.emit    = 1'b1;
          step_o.decoded = accum_i;
        end
      end
      esd_pkg::PH_OCT3: begin
        step_o.emit = 1'b1;
        if (is_oct) begin
          // Third digit: the top bits fall off, which wraps the value to a byte.
          step_o.decoded  = {accum_i[4:0], ch_i[2:0]};
          step_o.consumed = 1'b1;
        end else begin
          step_o.decoded = accum_i;
        end
      end
      default: begin
        // Start phase: the letter right after the backslash.
        step_o.emit     = 1'b1;
        step_o.consumed = 1'b1;
        case (ch_i)
          esd_pkg::CH_LO_A: step_o.decoded = esd_pkg::CH_BEL;
          esd_pkg::CH_LO_B: step_o.decoded = esd_pkg::CH_BS;
          esd_pkg::CH_LO_F: step_o.decoded = esd_pkg::CH_FF;
          esd_pkg::CH_LO_N: step_o.decoded = esd_pkg::CH_LF;
          esd_pkg::CH_LO_R: step_o.decoded = esd_pkg::CH_CR;
          esd_pkg::CH_LO_T: step_o.decoded = esd_pkg::CH_TAB;
          esd_pkg::CH_LO_V: step_o.decoded = esd_pkg::CH_VT;
          esd_pkg::CH_LO_X: begin
            step_o.emit     = 1'b0;
            step_o.consumed = 1'b0;
            step_o.phase    = esd_pkg::PH_HEX1;
          end
          esd_pkg::CH_NUL: begin
            step_o.decoded  = esd_pkg::CH_BSLSH;
            step_o.invalid  = 1'b1;
            step_o.consumed = 1'b0;
          end
          default: begin
            if (is_oct) begin
              step_o.emit     = 1'b0;
              step_o.consumed = 1'b0;
              step_o.phase    = esd_pkg::PH_OCT2;
              step_o.accum    = {5'd0, ch_i[2:0]};
            end else begin
              step_o.decoded = ch_i;
            end
          end
        endcase
      end
    endcase
  end

endmodule

`default_nettype wire
